[rtl/hkl_pkg.sv]
`default_nettype none

package hkl_pkg;

    localparam int KEY_W     = 32;
    localparam int HASH_W    = 32;
    localparam int HANDLE_W  = 12;
    localparam int KEY_BYTES = 12;

    localparam int DEF_BUCKETS = 1024;
    localparam int DEF_ENTRIES = 4096;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_HEAD_RD,
        ST_HEAD_CHK,
        ST_ENT_CHK,
        ST_ALLOC,
        ST_LINK,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        RES_HIT,
        RES_NEW,
        RES_FULL
    } res_sel_t;

    typedef struct packed {
        logic     clr_step;
        logic     key_load;
        logic     hash_step;
        logic     mod_step;
        logic     walk_head;
        logic     walk_next;
        logic     alloc_write;
        logic     link_write;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic hash_last;
        logic mod_skip;
        logic mod_last;
        logic head_end;
        logic link_end;
        logic key_match;
        logic pool_full;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[rtl/hkl_if.sv]
`default_nettype none

interface hkl_key_if;
    logic                      valid;
    logic                      ready;
    logic [hkl_pkg::KEY_W-1:0] sprite_number;
    logic [hkl_pkg::KEY_W-1:0] mask_number;
    logic [hkl_pkg::KEY_W-1:0] color_offset;

    modport source (
        output valid, sprite_number, mask_number, color_offset,
        input  ready
    );
    modport sink (
        input  valid, sprite_number, mask_number, color_offset,
        output ready
    );
endinterface

interface hkl_res_if;
    logic                         valid;
    logic                         ready;
    logic [hkl_pkg::HANDLE_W-1:0] entry_handle;
    logic                         found;
    logic                         table_full;

    modport source (
        output valid, entry_handle, found, table_full,
        input  ready
    );
    modport sink (
        input  valid, entry_handle, found, table_full,
        output ready
    );
endinterface

`default_nettype wire

[rtl/hkl_ctrl.sv]
`default_nettype none

module hkl_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire hkl_pkg::status_t status,
    output hkl_pkg::cmd_t         cmd
);
    import hkl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = RES_HIT;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.key_load = 1'b1;
                    state_next   = ST_HASH;
                end
            end
            ST_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (status.hash_last)
                begin
                    state_next = status.mod_skip ? ST_HEAD_RD : ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_last)
                begin
                    state_next = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD:
            begin
                state_next = ST_HEAD_CHK;
            end
            ST_HEAD_CHK:
            begin
                if (status.head_end)
                begin
                    state_next = ST_ALLOC;
                end
                else
                begin
                    cmd.walk_head = 1'b1;
                    state_next    = ST_ENT_CHK;
                end
            end
            ST_ENT_CHK:
            begin
                if (status.key_match)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_HIT;
                    state_next   = ST_RESULT;
                end
                else
                begin
                    // current entry becomes the tail, follow its link
                    cmd.walk_next = 1'b1;
                    if (status.link_end)
                    begin
                        state_next = ST_ALLOC;
                    end
                end
            end
            ST_ALLOC:
            begin
                if (status.pool_full)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_FULL;
                    state_next   = ST_RESULT;
                end
                else
                begin
                    cmd.alloc_write = 1'b1;
                    state_next      = ST_LINK;
                end
            end
            ST_LINK:
            begin
                cmd.link_write = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_sel    = RES_NEW;
                state_next     = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/hkl_dp.sv]
`default_nettype none

module hkl_dp #(
    parameter int BUCKETS = hkl_pkg::DEF_BUCKETS,
    parameter int ENTRIES = hkl_pkg::DEF_ENTRIES
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire hkl_pkg::cmd_t                cmd,
    output hkl_pkg::status_t                  status,
    input  wire logic [hkl_pkg::KEY_W-1:0]    sprite_number,
    input  wire logic [hkl_pkg::KEY_W-1:0]    mask_number,
    input  wire logic [hkl_pkg::KEY_W-1:0]    color_offset,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [hkl_pkg::HANDLE_W-1:0]      entry_handle,
    output logic                              found,
    output logic                              table_full
);
    import hkl_pkg::*;

    localparam int  BW         = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int  EW         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int  LW         = $clog2(ENTRIES + 1);
    localparam int  FW         = 3 * KEY_W;
    localparam int  CW         = $clog2(KEY_BYTES);
    localparam int  MW         = 2;
    localparam int  MOD_STAGES = 3;
    localparam int  LD         = $clog2(BUCKETS);
    localparam int  QW         = HASH_W + 1;
    localparam bit  BKT_POW2   = (BUCKETS & (BUCKETS - 1)) == 0;
    // ceil(2^(32+LD) / BUCKETS): exact quotient for every 32-bit hash
    localparam logic [QW-1:0] RECIP =
        QW'(((64'd1 << (HASH_W + LD)) / 64'(BUCKETS)) + 64'd1);

    // links hold entry index + 1, zero ends a chain
    logic [LW-1:0] head_mem [BUCKETS];
    logic [LW-1:0] link_mem [ENTRIES];
    logic [FW-1:0] key_mem  [ENTRIES];

    logic [LW-1:0] head_q;
    logic [LW-1:0] link_q;
    logic [FW-1:0] key_q;

    logic [FW-1:0]        key_reg;
    logic [HASH_W-1:0]    hash_reg;
    logic [CW-1:0]        byte_reg;
    logic [MW-1:0]        mod_cnt_reg;
    logic [HASH_W+QW-1:0] prod_reg;
    logic [HASH_W-1:0]    qd_reg;
    logic [BW-1:0]        rem_reg;
    logic [BW-1:0]        clr_reg;
    logic [EW-1:0]        cur_reg;
    logic [EW-1:0]        tail_reg;
    logic                 have_tail_reg;
    logic [LW-1:0]        used_reg;

    logic [HANDLE_W-1:0] res_handle_reg;
    logic                res_found_reg;
    logic                res_full_reg;
    logic                out_valid_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic                out_found_reg;
    logic                out_full_reg;

    logic [7:0]        key_byte;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] quot;
    logic [BW-1:0]     bucket;
    logic [LW-1:0]     rd_link;
    logic [LW-1:0]     rd_minus;
    logic [EW-1:0]     rd_idx;
    logic [EW-1:0]     used_idx;
    logic [LW-1:0]     used_plus;

    assign key_byte  = key_reg[8 * byte_reg +: 8];
    assign hash_next = (hash_reg * FNV_PRIME) ^ {{(HASH_W - 8){1'b0}}, key_byte};

    // remainder in three steps: hash times reciprocal, quotient times BUCKETS,
    // then subtract from the hash
    assign quot = HASH_W'(prod_reg >> (HASH_W + LD));

    assign bucket = BKT_POW2 ? BW'(hash_reg & HASH_W'(BUCKETS - 1)) : rem_reg;

    assign rd_link   = cmd.walk_head ? head_q : link_q;
    assign rd_minus  = rd_link - LW'(1);
    assign rd_idx    = rd_minus[EW-1:0];
    assign used_idx  = used_reg[EW-1:0];
    assign used_plus = used_reg + LW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            head_mem[clr_reg] <= '0;
        end
        else if (cmd.link_write && !have_tail_reg)
        begin
            head_mem[bucket] <= used_plus;
        end
        head_q <= head_mem[bucket];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc_write)
        begin
            link_mem[used_idx] <= '0;
        end
        else if (cmd.link_write && have_tail_reg)
        begin
            link_mem[tail_reg] <= used_plus;
        end
        link_q <= link_mem[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc_write)
        begin
            key_mem[used_idx] <= key_reg;
        end
        key_q <= key_mem[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.key_load)
        begin
            key_reg <= {color_offset, mask_number, sprite_number};
        end
        if (cmd.key_load)
        begin
            hash_reg <= FNV_BASIS;
        end
        else if (cmd.hash_step)
        begin
            hash_reg <= hash_next;
        end
        if (cmd.mod_step)
        begin
            prod_reg <= hash_reg * RECIP;
            qd_reg   <= quot * HASH_W'(BUCKETS);
        end
        if (cmd.key_load)
        begin
            rem_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            rem_reg <= BW'(hash_reg - qd_reg);
        end
        if (cmd.walk_head || cmd.walk_next)
        begin
            cur_reg <= rd_idx;
        end
        if (cmd.walk_next)
        begin
            tail_reg <= cur_reg;
        end
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                RES_HIT:
                begin
                    res_handle_reg <= HANDLE_W'(cur_reg);
                    res_found_reg  <= 1'b1;
                    res_full_reg   <= 1'b0;
                end
                RES_NEW:
                begin
                    res_handle_reg <= HANDLE_W'(used_idx);
                    res_found_reg  <= 1'b0;
                    res_full_reg   <= 1'b0;
                end
                default:
                begin
                    res_handle_reg <= '0;
                    res_found_reg  <= 1'b0;
                    res_full_reg   <= 1'b1;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out_handle_reg <= res_handle_reg;
            out_found_reg  <= res_found_reg;
            out_full_reg   <= res_full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg      <= '0;
            mod_cnt_reg   <= '0;
            clr_reg       <= '0;
            have_tail_reg <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.key_load)
            begin
                byte_reg    <= '0;
                mod_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.hash_step)
                begin
                    byte_reg <= byte_reg + CW'(1);
                end
                if (cmd.mod_step)
                begin
                    mod_cnt_reg <= mod_cnt_reg + MW'(1);
                end
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + BW'(1);
            end
            if (cmd.key_load)
            begin
                have_tail_reg <= 1'b0;
            end
            else if (cmd.walk_next)
            begin
                have_tail_reg <= 1'b1;
            end
            if (cmd.link_write)
            begin
                used_reg <= used_plus;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.clr_last  = clr_reg == BW'(BUCKETS - 1);
        status.hash_last = byte_reg == CW'(KEY_BYTES - 1);
        status.mod_skip  = BKT_POW2;
        status.mod_last  = mod_cnt_reg == MW'(MOD_STAGES - 1);
        status.head_end  = (head_q == '0) || (head_q > LW'(ENTRIES));
        status.link_end  = (link_q == '0) || (link_q > LW'(ENTRIES));
        status.key_match = key_q == key_reg;
        status.pool_full = used_reg == LW'(ENTRIES);
        status.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign entry_handle = out_handle_reg;
    assign found        = out_found_reg;
    assign table_full   = out_full_reg;

endmodule

`default_nettype wire

[rtl/hashed_key_lookup_or_insert.sv]
`default_nettype none

// Lookup-or-insert on a chained hash table keyed by three 32-bit words.
// One key at a time: FNV-1 hashing of the 12 key bytes, one byte per cycle,
// then remainder by reciprocal multiplication when BUCKETS is not a power of
// two, a read of the bucket head, chain entries compared one per cycle, then
// allocation and linking of a new entry (ST_ALLOC then ST_LINK; only ST_ALLOC
// when the pool is full, neither on a hit), the hand-off of the result to the
// output register and the return to idle to take the next key. The hand-off
// waits while the output register still holds an unaccepted word. After reset
// the bucket heads are cleared one per cycle with key_in.ready low. The output
// register holds one word, so the next key is taken while a result still waits.
module hashed_key_lookup_or_insert #(
    parameter int BUCKETS = hkl_pkg::DEF_BUCKETS,
    parameter int ENTRIES = hkl_pkg::DEF_ENTRIES
) (
    input wire logic clk,
    input wire logic rst_n,
    hkl_key_if.sink  key_in,
    hkl_res_if.source result
);
    import hkl_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    assign key_in.ready = in_ready;

    hkl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (key_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    hkl_dp #(
        .BUCKETS (BUCKETS),
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .sprite_number (key_in.sprite_number),
        .mask_number   (key_in.mask_number),
        .color_offset  (key_in.color_offset),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .entry_handle  (result.entry_handle),
        .found         (result.found),
        .table_full    (result.table_full)
    );

endmodule

`default_nettype wire

[sim/tb_hashed_key_lookup_or_insert.sv]
`timescale 1ns / 1ps

module tb_hashed_key_lookup_or_insert;

    import hkl_pkg::*;

    localparam int BUCKETS        = DEF_BUCKETS;
    localparam int ENTRIES        = DEF_ENTRIES;
    localparam int DIRECTED_ROWS  = 20;
    localparam int RANDOM_ITEMS   = 880;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int MAX_REKEY      = 50000;

    typedef struct packed {
        logic [KEY_W-1:0] sprite;
        logic [KEY_W-1:0] mask;
        logic [KEY_W-1:0] offset;
    } key_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                found;
        logic                full;
    } lookup_t;

    typedef struct packed {
        key_t    key;
        logic    typed;
        lookup_t result;
    } dir_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    hkl_key_if key_if ();
    hkl_res_if res_if ();

    hashed_key_lookup_or_insert #(
        .BUCKETS (BUCKETS),
        .ENTRIES (ENTRIES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .key_in (key_if),
        .result (res_if)
    );

    always #5 clk = ~clk;

    // shadow table
    int unsigned chain_head [BUCKETS];
    int unsigned chain_next [ENTRIES];
    key_t        pool_key   [ENTRIES];
    int unsigned pool_used;

    lookup_t     expected_results [$];
    int unsigned error_count = 0;
    int unsigned idle_count  = 0;
    int unsigned hot_bucket [3];
    bit          steady;

    // key, typed flag, typed result {handle, found, full}
    dir_row_t dir_rows [DIRECTED_ROWS] = '{
        {32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 12'd0,  1'b0, 1'b0},
        {32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 12'd0,  1'b1, 1'b0},
        {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 12'd1,  1'b0, 1'b0},
        {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 12'd1,  1'b1, 1'b0},
        {32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 12'd2,  1'b0, 1'b0},
        {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 12'd3,  1'b0, 1'b0},
        {32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 12'd4,  1'b0, 1'b0},
        {32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b1, 12'd5,  1'b0, 1'b0},
        {32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 1'b1, 12'd6,  1'b0, 1'b0},
        {32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1, 12'd7,  1'b0, 1'b0},
        {32'h0100_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 12'd8,  1'b0, 1'b0},
        {32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 12'd9,  1'b0, 1'b0},
        {32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 1'b1, 12'd10, 1'b0, 1'b0},
        {32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1, 12'd11, 1'b0, 1'b0},
        {32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 12'd0,  1'b1, 1'b0},
        {32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 12'd2,  1'b1, 1'b0},
        {32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1, 12'd7,  1'b1, 1'b0},
        {32'h0000_FFFF, 32'hFFFF_0000, 32'h00FF_00FF, 1'b0, 12'd0,  1'b0, 1'b0},
        {32'h0000_FFFF, 32'hFFFF_0000, 32'h00FF_00FF, 1'b0, 12'd0,  1'b0, 1'b0},
        {32'h5555_5555, 32'hAAAA_AAAA, 32'h5A5A_5A5A, 1'b0, 12'd0,  1'b0, 1'b0}
    };

    // FNV-1 over the 12 key bytes, each word low byte first
    function automatic logic [HASH_W-1:0] fnv1_hash(key_t k);
        logic [HASH_W-1:0]  h;
        logic [3*KEY_W-1:0] bytes_le;
        h = FNV_BASIS;
        bytes_le = {k.offset, k.mask, k.sprite};
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            h = h * FNV_PRIME;
            h = h ^ {24'd0, bytes_le[8*i +: 8]};
        end
        return h;
    endfunction

    function automatic int unsigned bucket_of(key_t k);
        return fnv1_hash(k) % BUCKETS;
    endfunction

    // walk the chain; on a miss append a pool entry unless the pool is spent
    function automatic lookup_t lookup_or_insert(key_t k);
        int unsigned bucket;
        int unsigned link;
        int unsigned tail;
        int unsigned steps;
        bit          have_tail;
        logic [31:0] idx;
        lookup_t     r;
        bucket    = bucket_of(k);
        link      = chain_head[bucket];
        tail      = 0;
        have_tail = 1'b0;
        for (steps = 0; link != 0 && steps < ENTRIES; steps++)
        begin
            if (link - 1 >= ENTRIES)
                break;
            if (pool_key[link - 1] == k)
            begin
                idx      = link - 1;
                r.handle = idx[HANDLE_W-1:0];
                r.found  = 1'b1;
                r.full   = 1'b0;
                return r;
            end
            tail      = link - 1;
            have_tail = 1'b1;
            link      = chain_next[link - 1];
        end
        if (pool_used >= ENTRIES)
        begin
            r.handle = '0;
            r.found  = 1'b0;
            r.full   = 1'b1;
            return r;
        end
        idx             = pool_used;
        pool_used       = pool_used + 1;
        pool_key[idx]   = k;
        chain_next[idx] = 0;
        if (have_tail)
            chain_next[tail] = idx + 1;
        else
            chain_head[bucket] = idx + 1;
        r.handle = idx[HANDLE_W-1:0];
        r.found  = 1'b0;
        r.full   = 1'b0;
        return r;
    endfunction

    // reroll one key word until the key lands in the target bucket
    function automatic key_t rekey_into_bucket(key_t base, int unsigned target,
                                               int unsigned word);
        key_t        k;
        int unsigned tries;
        k = base;
        for (tries = 0; tries < MAX_REKEY; tries++)
        begin
            case (word)
                0:       k.sprite = $urandom;
                1:       k.mask   = $urandom;
                default: k.offset = $urandom;
            endcase
            if (bucket_of(k) == target)
                break;
        end
        return k;
    endfunction

    function automatic key_t random_key();
        key_t        k;
        key_t        old;
        int unsigned pick;
        pick     = $urandom_range(0, 99);
        k.sprite = $urandom;
        k.mask   = $urandom;
        k.offset = $urandom;
        old      = pool_used != 0 ? pool_key[$urandom_range(0, pool_used - 1)] : k;
        if (pick < 30 && pool_used != 0)
            k = old;
        else if (pick < 45 && pool_used != 0)
            // near miss: same bucket, one word differs
            k = rekey_into_bucket(old, bucket_of(old), $urandom_range(0, 2));
        else if (pick < 55)
            k = rekey_into_bucket(k, hot_bucket[$urandom_range(0, 2)],
                                  $urandom_range(0, 2));
        else if (pick < 70)
        begin
            // typical use: small sprite index, mask and offset often unused
            k.sprite = $urandom_range(0, 2047);
            k.mask   = pick < 62 ? '0 : KEY_W'($urandom_range(0, 15));
            k.offset = pick < 66 ? '0 : KEY_W'($urandom_range(0, 255));
        end
        return k;
    endfunction

    function automatic int unsigned idle_cycles();
        return steady ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic send_key(input key_t k, input logic typed, input lookup_t typed_res);
        int unsigned gap;
        lookup_t     predicted;
        if ($urandom_range(0, 39) == 0)
            steady = !steady;
        gap = idle_cycles();
        if (gap != 0)
        begin
            key_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        key_if.valid         <= 1'b1;
        key_if.sprite_number <= k.sprite;
        key_if.mask_number   <= k.mask;
        key_if.color_offset  <= k.offset;
        do @(posedge clk); while (key_if.ready !== 1'b1);
        predicted = lookup_or_insert(k);
        expected_results.push_back(typed ? typed_res : predicted);
        @(negedge clk);
    endtask

    // cycles with no word accepted on either side
    always @(posedge clk)
    begin
        if ((key_if.valid && key_if.ready) || (res_if.valid && res_if.ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : result_sink
        lookup_t     want;
        lookup_t     got;
        int unsigned stall;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = idle_cycles();
            if (stall != 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (res_if.valid !== 1'b1);
            got = {res_if.entry_handle, res_if.found, res_if.table_full};
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: expected no result, got handle=%0d found=%b full=%b",
                         $time, got.handle, got.found, got.full);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    $display("%0t: expected handle=%0d found=%b full=%b,",
                             $time, want.handle, want.found, want.full,
                             " got handle=%0d found=%b full=%b",
                             got.handle, got.found, got.full);
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int unsigned n;
        lookup_t     no_result;
        no_result            = '0;
        pool_used            = 0;
        steady               = 1'b0;
        key_if.valid         = 1'b0;
        key_if.sprite_number = '0;
        key_if.mask_number   = '0;
        key_if.color_offset  = '0;
        for (n = 0; n < BUCKETS; n++)
            chain_head[n] = 0;
        hot_bucket[0] = 0;
        hot_bucket[1] = BUCKETS - 1;
        hot_bucket[2] = $urandom_range(1, BUCKETS - 2);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (n = 0; n < DIRECTED_ROWS; n++)
            send_key(dir_rows[n].key, dir_rows[n].typed, dir_rows[n].result);

        for (n = 0; n < RANDOM_ITEMS; n++)
            send_key(random_key(), 1'b0, no_result);

        key_if.valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/hkl_pkg.sv
rtl/hkl_if.sv
rtl/hkl_ctrl.sv
rtl/hkl_dp.sv
rtl/hashed_key_lookup_or_insert.sv
sim/tb_hashed_key_lookup_or_insert.sv
